// ----- hw/rtl/msa_pkg.sv -----
// shared types and constants for the special-group execute unit
package msa_pkg;

   localparam int unsigned DataWidth = 64;

   typedef enum logic [5:0] {
      FN_SLL    = 6'd0,  FN_SRL    = 6'd2,  FN_SRA    = 6'd3,
      FN_SLLV   = 6'd4,  FN_SRLV   = 6'd6,  FN_SRAV   = 6'd7,
      FN_MFHI   = 6'd16, FN_MTHI   = 6'd17, FN_MFLO   = 6'd18,
      FN_MTLO   = 6'd19, FN_DSLLV  = 6'd20, FN_DSRLV  = 6'd22,
      FN_DSRAV  = 6'd23, FN_MULT   = 6'd24, FN_MULTU  = 6'd25,
      FN_DIV    = 6'd26, FN_DIVU   = 6'd27, FN_DMULT  = 6'd28,
      FN_DMULTU = 6'd29, FN_DDIV   = 6'd30, FN_DDIVU  = 6'd31,
      FN_ADD    = 6'd32, FN_ADDU   = 6'd33, FN_SUB    = 6'd34,
      FN_SUBU   = 6'd35, FN_AND    = 6'd36, FN_OR     = 6'd37,
      FN_XOR    = 6'd38, FN_NOR    = 6'd39, FN_SLT    = 6'd42,
      FN_SLTU   = 6'd43, FN_DADD   = 6'd44, FN_DADDU  = 6'd45,
      FN_DSUB   = 6'd46, FN_DSUBU  = 6'd47, FN_DSLL   = 6'd56,
      FN_DSRL   = 6'd58, FN_DSRA   = 6'd59, FN_DSLL32 = 6'd60,
      FN_DSRL32 = 6'd62, FN_DSRA32 = 6'd63
   } funct_type;

   typedef enum logic [1:0] {
      ST_OK = 2'd0, ST_DIV_ZERO = 2'd1, ST_UNSUPPORTED = 2'd2
   } status_type;

   // operation classes handed from controller to datapath
   typedef enum logic [1:0] {
      CL_SIMPLE = 2'd0, CL_MUL = 2'd1, CL_DIV = 2'd2
   } class_type;

   typedef struct packed {
      logic      load;      // capture operands and start
      class_type op_class;
      logic      step;      // one iteration of mul/div
      logic      finish;    // post-process and commit hi/lo or result
   } cmd_type;

   typedef struct packed {
      logic       div_zero;
      logic       last_step;
   } stat_type;

   function automatic logic [63:0] sext32(input logic [31:0] x);
      return {{32{x[31]}}, x};
   endfunction

   function automatic logic [63:0] neg64(input logic [63:0] x);
      return 64'd0 - x;
   endfunction

endpackage

// ----- hw/rtl/msa_ctrl.sv -----
// controller: handshake and sequencing of the iterative multiply/divide
module msa_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [5:0]        req_type,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output msa_pkg::cmd_type  cmd,
   input  msa_pkg::stat_type stat
);

   typedef enum logic [1:0] {S_IDLE, S_RUN, S_FINISH, S_OUT} state_type;

   state_type          state_ff, state_in;
   msa_pkg::class_type class_ff, class_in;
   msa_pkg::class_type req_class;

   always_comb begin
      unique case (req_type)
         msa_pkg::FN_MULT, msa_pkg::FN_MULTU,
         msa_pkg::FN_DMULT, msa_pkg::FN_DMULTU: req_class = msa_pkg::CL_MUL;
         msa_pkg::FN_DIV, msa_pkg::FN_DIVU,
         msa_pkg::FN_DDIV, msa_pkg::FN_DDIVU:   req_class = msa_pkg::CL_DIV;
         default:                               req_class = msa_pkg::CL_SIMPLE;
      endcase
   end

   // output register frees up when taken; a new beat may enter then
   wire out_free = (state_ff == S_OUT) && !rsp_stall;
   wire can_take = (state_ff == S_IDLE) || out_free;
   wire take     = can_take && req_valid;

   assign req_stall = !can_take;
   assign rsp_valid = (state_ff == S_OUT);

   always_comb begin
      cmd          = '0;
      cmd.op_class = class_ff;
      state_in     = state_ff;
      class_in     = class_ff;
      if (out_free) state_in = S_IDLE;
      unique case (state_ff)
         S_RUN: begin
            cmd.step = 1'b1;
            if (stat.last_step) state_in = S_FINISH;
         end
         S_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = S_OUT;
         end
         default: ;
      endcase
      if (take) begin
         cmd.load     = 1'b1;
         cmd.op_class = req_class;
         class_in     = req_class;
         if (req_class == msa_pkg::CL_SIMPLE ||
             (req_class == msa_pkg::CL_DIV && stat.div_zero)) state_in = S_FINISH;
         else state_in = S_RUN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         class_ff <= msa_pkg::CL_SIMPLE;
      end else begin
         state_ff <= state_in;
         class_ff <= class_in;
      end
   end

endmodule

// ----- hw/rtl/msa_datapath.sv -----
// datapath: operand registers, simple alu, shift-add multiplier, restoring divider, hi/lo
module msa_datapath (
   input  logic              clock,
   input  logic              reset,
   input  logic [5:0]        req_type,
   input  logic [63:0]       req_rs_value,
   input  logic [63:0]       req_rt_value,
   input  logic [4:0]        req_shift_amount,
   input  logic [4:0]        req_dest_index,
   input  msa_pkg::cmd_type  cmd,
   output msa_pkg::stat_type stat,
   output logic [63:0]       rsp_result_value,
   output logic [4:0]        rsp_dest_out,
   output logic              rsp_write_dest,
   output logic [1:0]        rsp_status
);

   logic [63:0] hi_ff, hi_in, lo_ff, lo_in;
   logic [63:0] res_ff, res_in;
   logic [4:0]  dest_ff;
   logic        wr_ff, wr_in;
   logic [1:0]  st_ff, st_in;
   logic [5:0]  fn_ff;
   logic [63:0] rs_ff, rt_ff;
   logic [4:0]  sa_ff;
   // iteration state: a = multiplicand/divisor, acc = partial hi / remainder,
   // q = multiplier / quotient shifting register
   logic [63:0] a_ff, a_in, acc_ff, acc_in, q_ff, q_in;
   logic        carry_ff, carry_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        nq_ff, nr_ff;

   wire msa_pkg::funct_type fn_req = msa_pkg::funct_type'(req_type);
   wire msa_pkg::funct_type fn     = msa_pkg::funct_type'(fn_ff);

   wire is32_req = (fn_req == msa_pkg::FN_MULT) || (fn_req == msa_pkg::FN_MULTU) ||
                   (fn_req == msa_pkg::FN_DIV) || (fn_req == msa_pkg::FN_DIVU);
   wire sgn_req  = (fn_req == msa_pkg::FN_MULT) || (fn_req == msa_pkg::FN_DIV) ||
                   (fn_req == msa_pkg::FN_DMULT) || (fn_req == msa_pkg::FN_DDIV);

   // operands widened per op; 32-bit ops use sign- or zero-extended halves
   logic [63:0] op_a, op_b, mag_a, mag_b;
   always_comb begin
      if (is32_req && sgn_req) begin
         op_a = msa_pkg::sext32(req_rs_value[31:0]);
         op_b = msa_pkg::sext32(req_rt_value[31:0]);
      end else if (is32_req) begin
         op_a = {32'd0, req_rs_value[31:0]};
         op_b = {32'd0, req_rt_value[31:0]};
      end else begin
         op_a = req_rs_value;
         op_b = req_rt_value;
      end
      mag_a = (sgn_req && op_a[63]) ? msa_pkg::neg64(op_a) : op_a;
      mag_b = (sgn_req && op_b[63]) ? msa_pkg::neg64(op_b) : op_b;
   end

   assign stat.div_zero  = (op_b == 64'd0);
   assign stat.last_step = (cnt_ff == 6'd63);

   // one multiply step: add multiplicand if lsb set, shift right 1
   wire [64:0]  mul_sum = {1'b0, acc_ff} + (q_ff[0] ? {1'b0, a_ff} : 65'd0);
   // one divide step: shift remainder left, try subtract
   wire [64:0]  rem_sh  = {acc_ff, q_ff[63]};
   wire [64:0]  rem_sub = rem_sh - {1'b0, a_ff};
   wire         fits    = !rem_sub[64];

   // simple ops
   logic [63:0] simple;
   logic [31:0] sh32;
   logic [63:0] sra32src;
   logic [4:0]  vsa5;
   logic [5:0]  vsa6, dsa32;
   always_comb begin
      vsa5     = rs_ff[4:0];
      vsa6     = rs_ff[5:0];
      dsa32    = {1'b1, sa_ff};
      sra32src = msa_pkg::sext32(rt_ff[31:0]);
      sh32     = '0;
      simple   = '0;
      unique case (fn)
         msa_pkg::FN_SLL:  begin sh32 = rt_ff[31:0] << sa_ff; simple = msa_pkg::sext32(sh32); end
         msa_pkg::FN_SRL:  begin sh32 = rt_ff[31:0] >> sa_ff; simple = msa_pkg::sext32(sh32); end
         msa_pkg::FN_SRA:  simple = $signed(sra32src) >>> sa_ff;
         msa_pkg::FN_SLLV: begin sh32 = rt_ff[31:0] << vsa5; simple = msa_pkg::sext32(sh32); end
         msa_pkg::FN_SRLV: begin sh32 = rt_ff[31:0] >> vsa5; simple = msa_pkg::sext32(sh32); end
         msa_pkg::FN_SRAV: simple = $signed(sra32src) >>> vsa5;
         msa_pkg::FN_MFHI: simple = hi_ff;
         msa_pkg::FN_MFLO: simple = lo_ff;
         msa_pkg::FN_DSLLV: simple = rt_ff << vsa6;
         msa_pkg::FN_DSRLV: simple = rt_ff >> vsa6;
         msa_pkg::FN_DSRAV: simple = $signed(rt_ff) >>> vsa6;
         msa_pkg::FN_ADD, msa_pkg::FN_ADDU:
            simple = msa_pkg::sext32(rs_ff[31:0] + rt_ff[31:0]);
         msa_pkg::FN_SUB, msa_pkg::FN_SUBU:
            simple = msa_pkg::sext32(rs_ff[31:0] - rt_ff[31:0]);
         msa_pkg::FN_AND: simple = rs_ff & rt_ff;
         msa_pkg::FN_OR:  simple = rs_ff | rt_ff;
         msa_pkg::FN_XOR: simple = rs_ff ^ rt_ff;
         msa_pkg::FN_NOR: simple = ~(rs_ff | rt_ff);
         msa_pkg::FN_SLT:  simple = {63'd0, $signed(rs_ff) < $signed(rt_ff)};
         msa_pkg::FN_SLTU: simple = {63'd0, rs_ff < rt_ff};
         msa_pkg::FN_DADD, msa_pkg::FN_DADDU: simple = rs_ff + rt_ff;
         msa_pkg::FN_DSUB, msa_pkg::FN_DSUBU: simple = rs_ff - rt_ff;
         msa_pkg::FN_DSLL:   simple = rt_ff << sa_ff;
         msa_pkg::FN_DSRL:   simple = rt_ff >> sa_ff;
         msa_pkg::FN_DSRA:   simple = $signed(rt_ff) >>> sa_ff;
         msa_pkg::FN_DSLL32: simple = rt_ff << dsa32;
         msa_pkg::FN_DSRL32: simple = rt_ff >> dsa32;
         msa_pkg::FN_DSRA32: simple = $signed(rt_ff) >>> dsa32;
         default: simple = '0;
      endcase
   end

   logic nodest, unsup, fn32, fsgn;
   logic [63:0] qf, rf;
   always_comb begin
      unsup = 1'b0;
      unique case (fn)
         msa_pkg::FN_SLL, msa_pkg::FN_SRL, msa_pkg::FN_SRA, msa_pkg::FN_SLLV,
         msa_pkg::FN_SRLV, msa_pkg::FN_SRAV, msa_pkg::FN_MFHI, msa_pkg::FN_MTHI,
         msa_pkg::FN_MFLO, msa_pkg::FN_MTLO, msa_pkg::FN_DSLLV, msa_pkg::FN_DSRLV,
         msa_pkg::FN_DSRAV, msa_pkg::FN_MULT, msa_pkg::FN_MULTU, msa_pkg::FN_DIV,
         msa_pkg::FN_DIVU, msa_pkg::FN_DMULT, msa_pkg::FN_DMULTU, msa_pkg::FN_DDIV,
         msa_pkg::FN_DDIVU, msa_pkg::FN_ADD, msa_pkg::FN_ADDU, msa_pkg::FN_SUB,
         msa_pkg::FN_SUBU, msa_pkg::FN_AND, msa_pkg::FN_OR, msa_pkg::FN_XOR,
         msa_pkg::FN_NOR, msa_pkg::FN_SLT, msa_pkg::FN_SLTU, msa_pkg::FN_DADD,
         msa_pkg::FN_DADDU, msa_pkg::FN_DSUB, msa_pkg::FN_DSUBU, msa_pkg::FN_DSLL,
         msa_pkg::FN_DSRL, msa_pkg::FN_DSRA, msa_pkg::FN_DSLL32, msa_pkg::FN_DSRL32,
         msa_pkg::FN_DSRA32: unsup = 1'b0;
         default: unsup = 1'b1;
      endcase
      nodest = (fn == msa_pkg::FN_MTHI) || (fn == msa_pkg::FN_MTLO) ||
               (cmd.op_class != msa_pkg::CL_SIMPLE) || unsup;
      fn32 = (fn == msa_pkg::FN_MULT) || (fn == msa_pkg::FN_MULTU) ||
             (fn == msa_pkg::FN_DIV) || (fn == msa_pkg::FN_DIVU);
      fsgn = (fn == msa_pkg::FN_DMULT) || (fn == msa_pkg::FN_DDIV) ||
             (fn == msa_pkg::FN_DIV);
      qf = nq_ff ? msa_pkg::neg64(q_ff) : q_ff;
      rf = nr_ff ? msa_pkg::neg64(acc_ff) : acc_ff;
   end

   always_comb begin
      a_in = a_ff; acc_in = acc_ff; q_in = q_ff; carry_in = carry_ff;
      cnt_in = cnt_ff;
      hi_in = hi_ff; lo_in = lo_ff;
      res_in = res_ff; wr_in = wr_ff; st_in = st_ff;
      if (cmd.load) begin
         cnt_in = '0; acc_in = '0; carry_in = 1'b0;
         if (cmd.op_class == msa_pkg::CL_MUL) begin
            // 32-bit ops: full signed product fits in 64 bits of extended operands
            a_in = is32_req ? op_a : req_rs_value;
            q_in = is32_req ? op_b : req_rt_value;
         end else begin
            a_in = mag_b;
            q_in = mag_a;
         end
      end else if (cmd.step) begin
         cnt_in = cnt_ff + 6'd1;
         if (cmd.op_class == msa_pkg::CL_MUL) begin
            acc_in = mul_sum[64:1];
            q_in   = {mul_sum[0], q_ff[63:1]};
         end else begin
            acc_in = fits ? rem_sub[63:0] : rem_sh[63:0];
            q_in   = {q_ff[62:0], fits};
         end
      end
      if (cmd.finish) begin
         res_in = '0; wr_in = 1'b0; st_in = msa_pkg::ST_OK;
         if (unsup) begin
            st_in = msa_pkg::ST_UNSUPPORTED;
         end else if (cmd.op_class == msa_pkg::CL_MUL) begin
            if (fn32) begin
               hi_in = msa_pkg::sext32(q_ff[63:32]);
               lo_in = msa_pkg::sext32(q_ff[31:0]);
            end else begin
               hi_in = acc_ff - (fsgn && rs_ff[63] ? rt_ff : 64'd0)
                              - (fsgn && rt_ff[63] ? rs_ff : 64'd0);
               lo_in = q_ff;
            end
         end else if (cmd.op_class == msa_pkg::CL_DIV) begin
            if (carry_ff) begin
               st_in = msa_pkg::ST_DIV_ZERO;
            end else if (fn32) begin
               lo_in = msa_pkg::sext32(qf[31:0]);
               hi_in = msa_pkg::sext32(rf[31:0]);
            end else begin
               lo_in = qf;
               hi_in = rf;
            end
         end else begin
            if (fn == msa_pkg::FN_MTHI) hi_in = rs_ff;
            if (fn == msa_pkg::FN_MTLO) lo_in = rs_ff;
            if (!nodest) begin
               res_in = simple;
               wr_in  = (dest_ff != 5'd0);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hi_ff <= '0;
         lo_ff <= '0;
      end else begin
         hi_ff <= hi_in;
         lo_ff <= lo_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         fn_ff   <= req_type;
         rs_ff   <= req_rs_value;
         rt_ff   <= req_rt_value;
         sa_ff   <= req_shift_amount;
         dest_ff <= req_dest_index;
         nq_ff   <= sgn_req && (op_a[63] != op_b[63]);
         nr_ff   <= sgn_req && op_a[63];
         carry_ff <= (op_b == 64'd0);  // divide-by-zero flag for this beat
      end else begin
         carry_ff <= carry_in;
      end
      a_ff   <= a_in;
      acc_ff <= acc_in;
      q_ff   <= q_in;
      cnt_ff <= cnt_in;
      res_ff <= res_in;
      wr_ff  <= wr_in;
      st_ff  <= st_in;
   end

   assign rsp_result_value = res_ff;
   assign rsp_dest_out     = dest_ff;
   assign rsp_write_dest   = wr_ff;
   assign rsp_status       = st_ff;

endmodule

// ----- hw/rtl/mips64_special_alu_hilo_top.sv -----
// simple ops, unsupported codes and divide by zero go from the accepting edge through S_FINISH
//   to S_OUT, where rsp_valid is high; multiply/divide run 64 steps in S_RUN before S_FINISH
// no new beat is taken while a beat is in flight; multiply/divide run on the 64-step
//   shift-add multiplier and restoring divider that iterate one bit per cycle
// a new beat is taken in the cycle the pending result is taken
// reset (synchronous, active high) clears the controller and hi/lo to zero
module mips64_special_alu_hilo_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [5:0]  req_type,
   input  logic [63:0] req_rs_value,
   input  logic [63:0] req_rt_value,
   input  logic [4:0]  req_shift_amount,
   input  logic [4:0]  req_dest_index,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_result_value,
   output logic [4:0]  rsp_dest_out,
   output logic        rsp_write_dest,
   output logic [1:0]  rsp_status
);

   msa_pkg::cmd_type  cmd;
   msa_pkg::stat_type stat;

   msa_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .req_type,
      .rsp_valid, .rsp_stall, .cmd, .stat
   );

   msa_datapath u_dp (
      .clock, .reset, .req_type, .req_rs_value, .req_rt_value,
      .req_shift_amount, .req_dest_index, .cmd, .stat,
      .rsp_result_value, .rsp_dest_out, .rsp_write_dest, .rsp_status
   );

endmodule
